@@ rtl/core/hds_pkg.sv @@
// Shared constants, codes, types and helpers of the heat diffusion stencil block.
`timescale 1ns / 1ps

package hds_pkg;

  // Grid geometry
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int Cells    = MAX_ROWS * MAX_COLS;
  localparam int RowW     = $clog2(MAX_ROWS);
  localparam int ColW     = $clog2(MAX_COLS);
  localparam int AddrW    = $clog2(Cells);

  // Field widths
  localparam int DataW    = 32;
  localparam int IdxW     = 6;
  localparam int SizeW    = 7;
  localparam int CoefW    = 16;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  // Stencil arithmetic widths
  localparam int WinLen = 2 * MAX_COLS + 1;    // window: down .. center .. up
  localparam int DiffW  = DataW + 2;           // second difference
  localparam int ProdW  = DiffW + CoefW + 1;   // difference times coefficient
  localparam int SumW   = ProdW + 1;           // sum of both products
  localparam int FracW  = 16;                  // Q16.16 fraction bits
  localparam int DeltaW = SumW - FracW;

  localparam logic signed [SumW-1:0]  RoundHalf = SumW'(1 << (FracW - 1));
  localparam logic signed [DataW-1:0] SatMax    = {1'b0, {(DataW - 1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin    = {1'b1, {(DataW - 1){1'b0}}};

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_SET  = 2'd0,
    CMD_STEP = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROWS   = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLS   = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_COEF_X = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_COEF_Y = 4'd3;

  // Register reset values
  localparam logic [SizeW-1:0] RowsRst = SizeW'(MAX_ROWS);
  localparam logic [SizeW-1:0] ColsRst = SizeW'(MAX_COLS);
  localparam logic [CoefW-1:0] CoefRst = 16'd6554;

  // Controller to datapath commands
  typedef struct packed {
    logic            clr_we;    // write zero at sweep position
    logic            set_we;    // write host cell
    logic            host_rd;   // read host cell
    logic            sweep_rd;  // stream read at sweep position
    logic            val_load;  // capture read data into result
    logic [RowW-1:0] row;       // sweep position
    logic [ColW-1:0] col;
  } hds_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;            // stencil pipeline still holds cells
  } hds_stat_t;

  // Size registers hold 1..vmax; zero acts as one
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] vmax);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > vmax) r = vmax;
    return r;
  endfunction

endpackage

@@ rtl/core/hds_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module hds_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/hds_ctrl.sv @@
// Controller: command decode, clearing pass, grid sweep sequencing and result strobe.
`timescale 1ns / 1ps

module hds_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hds_pkg::CmdW-1:0]     cmd_i,
  input  logic [hds_pkg::IdxW-1:0]     row_i,
  input  logic [hds_pkg::IdxW-1:0]     col_i,
  input  logic [hds_pkg::SizeW-1:0]    rows_i,
  input  logic [hds_pkg::SizeW-1:0]    cols_i,
  input  hds_pkg::hds_stat_t           stat_i,
  output hds_pkg::hds_cmd_t            cmd_o,
  output logic                         busy_o,
  output logic                         done_o,
  output logic                         status_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DRAIN
  } state_e;

  state_e                        state_q;
  logic [hds_pkg::RowW-1:0]      row_q;
  logic [hds_pkg::ColW-1:0]      col_q;
  logic                          done_q;
  logic                          status_q;

  logic accept;
  logic in_grid;
  logic has_interior;
  logic col_last;
  logic row_last_grid;
  logic row_last_used;

  assign accept        = start_i && (state_q == ST_IDLE);
  assign in_grid       = (hds_pkg::SizeW'(row_i) < rows_i) &&
                         (hds_pkg::SizeW'(col_i) < cols_i);
  assign has_interior  = (rows_i >= hds_pkg::SizeW'(3)) && (cols_i >= hds_pkg::SizeW'(3));
  assign col_last      = (col_q == hds_pkg::ColW'(hds_pkg::MAX_COLS - 1));
  assign row_last_grid = (row_q == hds_pkg::RowW'(hds_pkg::MAX_ROWS - 1));
  assign row_last_used = (hds_pkg::SizeW'(row_q) == (rows_i - hds_pkg::SizeW'(1)));

  always_comb begin
    cmd_o          = '0;
    cmd_o.row      = row_q;
    cmd_o.col      = col_q;
    case (state_q)
      ST_CLEAR: cmd_o.clr_we   = 1'b1;
      ST_IDLE: begin
        cmd_o.set_we  = accept && (cmd_i == hds_pkg::CMD_SET) && in_grid;
        cmd_o.host_rd = accept && (cmd_i == hds_pkg::CMD_READ) && in_grid;
      end
      ST_READ:  cmd_o.val_load = 1'b1;
      ST_SWEEP: cmd_o.sweep_rd = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      row_q    <= '0;
      col_q    <= '0;
      done_q   <= 1'b0;
      status_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          col_q <= col_q + hds_pkg::ColW'(1);
          if (col_last) begin
            col_q <= '0;
            row_q <= row_q + hds_pkg::RowW'(1);
            if (row_last_grid) begin
              row_q   <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (cmd_i)
              hds_pkg::CMD_SET: begin
                done_q   <= 1'b1;
                status_q <= !in_grid;
              end
              hds_pkg::CMD_READ: begin
                if (in_grid) begin
                  state_q <= ST_READ;
                end else begin
                  done_q   <= 1'b1;
                  status_q <= 1'b1;
                end
              end
              hds_pkg::CMD_STEP: begin
                if (has_interior) begin
                  row_q   <= '0;
                  col_q   <= '0;
                  state_q <= ST_SWEEP;
                end else begin
                  done_q   <= 1'b1;
                  status_q <= 1'b0;
                end
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= 1'b0;
              end
            endcase
          end
        end
        ST_READ: begin
          done_q   <= 1'b1;
          status_q <= 1'b0;
          state_q  <= ST_IDLE;
        end
        ST_SWEEP: begin
          col_q <= col_q + hds_pkg::ColW'(1);
          if (col_last) begin
            col_q <= '0;
            row_q <= row_q + hds_pkg::RowW'(1);
            if (row_last_used) begin
              row_q   <= '0;
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!stat_i.pipe_busy) begin
            done_q   <= 1'b1;
            status_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while controller not idle");

  a_drain_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && !stat_i.pipe_busy) |=> done_q)
    else $error("drained step did not report");

  a_no_result_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !done_q)
    else $error("result strobe during grid sweep");

endmodule

@@ rtl/core/hds_datapath.sv @@
// Datapath: grid RAM, three-row sliding window and the stencil update pipeline.
`timescale 1ns / 1ps

module hds_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hds_pkg::hds_cmd_t                 cmd_i,
  input  logic [hds_pkg::IdxW-1:0]          row_i,
  input  logic [hds_pkg::IdxW-1:0]          col_i,
  input  logic signed [hds_pkg::DataW-1:0]  heat_i,
  input  logic [hds_pkg::SizeW-1:0]         cols_i,
  input  logic [hds_pkg::CoefW-1:0]         coef_x_i,
  input  logic [hds_pkg::CoefW-1:0]         coef_y_i,
  output logic signed [hds_pkg::DataW-1:0]  value_o,
  output hds_pkg::hds_stat_t                stat_o
);

  localparam int AW = hds_pkg::AddrW;
  localparam int DW = hds_pkg::DataW;

  // ---------------------------------------------------------------- grid RAM
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [DW-1:0]   rd_data;

  logic [AW-1:0]   host_addr;
  logic [AW-1:0]   sweep_addr;

  assign host_addr  = AW'(row_i) * AW'(hds_pkg::MAX_COLS) + AW'(col_i);
  assign sweep_addr = AW'(cmd_i.row) * AW'(hds_pkg::MAX_COLS) + AW'(cmd_i.col);

  hds_ram #(
    .Width (DW),
    .Depth (hds_pkg::Cells)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // ------------------------------------------------------- pipeline registers
  logic                              rd_vld_q;
  logic [hds_pkg::RowW-1:0]          rd_row_q;
  logic [hds_pkg::ColW-1:0]          rd_col_q;

  logic signed [DW-1:0]              win_q [hds_pkg::WinLen];
  logic                              win_vld_q;
  logic [hds_pkg::RowW-1:0]          win_row_q;
  logic [hds_pkg::ColW-1:0]          win_col_q;

  logic                              a_vld_q;
  logic signed [hds_pkg::DiffW-1:0]  a_dxx_q;
  logic signed [hds_pkg::DiffW-1:0]  a_dyy_q;
  logic signed [DW-1:0]              a_t_q;
  logic [AW-1:0]                     a_addr_q;

  logic                              b_vld_q;
  logic signed [hds_pkg::ProdW-1:0]  b_px_q;
  logic signed [hds_pkg::ProdW-1:0]  b_py_q;
  logic signed [DW-1:0]              b_t_q;
  logic [AW-1:0]                     b_addr_q;

  logic                              c_vld_q;
  logic signed [hds_pkg::SumW-1:0]   c_sum_q;
  logic signed [DW-1:0]              c_t_q;
  logic [AW-1:0]                     c_addr_q;

  logic signed [DW-1:0]              value_q;

  // ------------------------------------------------------- stencil, stage A
  // Newest cell is the one below the center; center sits MAX_COLS back.
  logic signed [hds_pkg::DiffW-1:0]  t_x, dn_x, up_x, lf_x, rt_x;
  logic signed [hds_pkg::DiffW-1:0]  dxx, dyy;
  logic                              interior;
  logic [AW-1:0]                     ctr_addr;

  assign t_x  = hds_pkg::DiffW'(win_q[hds_pkg::MAX_COLS]);
  assign dn_x = hds_pkg::DiffW'(win_q[0]);
  assign up_x = hds_pkg::DiffW'(win_q[2 * hds_pkg::MAX_COLS]);
  assign lf_x = hds_pkg::DiffW'(win_q[hds_pkg::MAX_COLS + 1]);
  assign rt_x = hds_pkg::DiffW'(win_q[hds_pkg::MAX_COLS - 1]);

  assign dxx = dn_x + up_x - (t_x <<< 1);
  assign dyy = rt_x + lf_x - (t_x <<< 1);

  assign interior = (win_row_q >= hds_pkg::RowW'(2)) && (win_col_q != '0) &&
                    ((hds_pkg::SizeW'(win_col_q) + hds_pkg::SizeW'(2)) <= cols_i);
  assign ctr_addr = AW'(win_row_q - hds_pkg::RowW'(1)) * AW'(hds_pkg::MAX_COLS) +
                    AW'(win_col_q);

  logic signed [hds_pkg::CoefW:0] cx_s, cy_s;
  assign cx_s = $signed({1'b0, coef_x_i});
  assign cy_s = $signed({1'b0, coef_y_i});

  // ---------------------------------------------- round, add, saturate (D)
  logic signed [hds_pkg::DeltaW-1:0] delta;
  logic signed [hds_pkg::DeltaW-1:0] upd;
  logic                              ovf;
  logic signed [DW-1:0]              upd_sat;

  assign delta   = $signed(c_sum_q[hds_pkg::SumW-1:hds_pkg::FracW]);
  assign upd     = delta + hds_pkg::DeltaW'(c_t_q);
  assign ovf     = (upd[hds_pkg::DeltaW-1:DW-1] != '0) && (upd[hds_pkg::DeltaW-1:DW-1] != '1);
  assign upd_sat = ovf ? (upd[hds_pkg::DeltaW-1] ? hds_pkg::SatMin : hds_pkg::SatMax)
                       : upd[DW-1:0];

  // ------------------------------------------------------- RAM port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_addr;
    ram_wdata = '0;
    if (cmd_i.clr_we) begin
      ram_we = 1'b1;
    end else if (cmd_i.set_we) begin
      ram_we    = 1'b1;
      ram_waddr = host_addr;
      ram_wdata = heat_i;
    end else if (c_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = c_addr_q;
      ram_wdata = upd_sat;
    end
  end

  assign ram_re    = cmd_i.host_rd || cmd_i.sweep_rd;
  assign ram_raddr = cmd_i.host_rd ? host_addr : sweep_addr;

  // ------------------------------------------------------------ valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      win_vld_q <= 1'b0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      value_q   <= '0;
    end else begin
      rd_vld_q  <= cmd_i.sweep_rd;
      win_vld_q <= rd_vld_q;
      a_vld_q   <= win_vld_q && interior;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      value_q   <= cmd_i.val_load ? $signed(rd_data) : '0;
    end
  end

  // ------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_rd) begin
      rd_row_q <= cmd_i.row;
      rd_col_q <= cmd_i.col;
    end
    if (rd_vld_q) begin
      win_q[0] <= $signed(rd_data);
      for (int n = 1; n < hds_pkg::WinLen; n++) begin
        win_q[n] <= win_q[n-1];
      end
      win_row_q <= rd_row_q;
      win_col_q <= rd_col_q;
    end
    a_dxx_q  <= dxx;
    a_dyy_q  <= dyy;
    a_t_q    <= win_q[hds_pkg::MAX_COLS];
    a_addr_q <= ctr_addr;
    b_px_q   <= a_dxx_q * cx_s;
    b_py_q   <= a_dyy_q * cy_s;
    b_t_q    <= a_t_q;
    b_addr_q <= a_addr_q;
    c_sum_q  <= hds_pkg::SumW'(b_px_q) + hds_pkg::SumW'(b_py_q) + hds_pkg::RoundHalf;
    c_t_q    <= b_t_q;
    c_addr_q <= b_addr_q;
  end

  assign value_o          = value_q;
  assign stat_o.pipe_busy = rd_vld_q || win_vld_q || a_vld_q || b_vld_q || c_vld_q;

  a_set_vs_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_we |-> !c_vld_q)
    else $error("host write collides with stencil write-back");

  a_clear_vs_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_we |-> !stat_o.pipe_busy)
    else $error("clearing pass while stencil pipeline active");

  a_jacobi_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_vld_q && cmd_i.sweep_rd) |-> (c_addr_q != sweep_addr))
    else $error("write-back hits a cell still to be read");

endmodule

@@ rtl/core/heat_diffusion_stencil_step.sv @@
// Top level of the 2-D explicit heat-equation stencil block: config registers and wiring.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Beat contents
// command   in         start & !busy              cmd_i, row_i, col_i, heat_i
// result    out        done_o (one-cycle strobe)  value_o, status_o
// config    in         cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// Reporting: set, step on a grid with no interior, and unused codes report in the
//   cycle after the command beat; read first passes the READ state, which captures
//   the RAM data, and then reports. A step streams the grid RAM read port one cell
//   per cycle over rows_used full rows and reports once the last write-back has
//   drained from the stencil pipeline; the single RAM read port sets that rate.
// Reset: a clearing pass writes zero to all 4096 cells, with busy held high
//   throughout. Config beats are taken at any time (ready tied high).
// Stalls: the result receiver cannot stall; busy alone throttles commands.
//
// Update per interior cell (Jacobi: all reads see the old grid):
//   new = sat32(T + round(cx*(Tdn - 2T + Tup) + cy*(Trt - 2T + Tlf)))
// The datapath keeps the last 2*64+1 streamed cells in a shift window, so up,
// down, left, right and center are fixed taps; the update is written back to
// the center address 69 cells behind the read pointer, which is never re-read.

module heat_diffusion_stencil_step (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic [hds_pkg::CmdW-1:0]               cmd_i,
  input  logic [hds_pkg::IdxW-1:0]               row_i,
  input  logic [hds_pkg::IdxW-1:0]               col_i,
  input  logic signed [hds_pkg::DataW-1:0]       heat_i,
  // result channel
  output logic                                   done_o,
  output logic signed [hds_pkg::DataW-1:0]       value_o,
  output logic                                   status_o,
  // config channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [hds_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [hds_pkg::CfgDataW-1:0]           cfg_data_i
);

  // Size registers are stored already clamped to 1..MAX.
  logic [hds_pkg::SizeW-1:0] rows_q;
  logic [hds_pkg::SizeW-1:0] cols_q;
  logic [hds_pkg::CoefW-1:0] coef_x_q;
  logic [hds_pkg::CoefW-1:0] coef_y_q;

  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= hds_pkg::RowsRst;
      cols_q   <= hds_pkg::ColsRst;
      coef_x_q <= hds_pkg::CoefRst;
      coef_y_q <= hds_pkg::CoefRst;
    end else if (cfg_we) begin
      case (cfg_index_i)
        hds_pkg::CFG_ROWS:
          rows_q <= hds_pkg::clamp_size(cfg_data_i[hds_pkg::SizeW-1:0], hds_pkg::RowsRst);
        hds_pkg::CFG_COLS:
          cols_q <= hds_pkg::clamp_size(cfg_data_i[hds_pkg::SizeW-1:0], hds_pkg::ColsRst);
        hds_pkg::CFG_COEF_X: coef_x_q <= cfg_data_i[hds_pkg::CoefW-1:0];
        hds_pkg::CFG_COEF_Y: coef_y_q <= cfg_data_i[hds_pkg::CoefW-1:0];
        default: ;  // indexes past the register list are dropped
      endcase
    end
  end

  hds_pkg::hds_cmd_t  ctl_cmd;
  hds_pkg::hds_stat_t dp_stat;

  hds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (cmd_i),
    .row_i    (row_i),
    .col_i    (col_i),
    .rows_i   (rows_q),
    .cols_i   (cols_q),
    .stat_i   (dp_stat),
    .cmd_o    (ctl_cmd),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_o (status_o)
  );

  hds_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ctl_cmd),
    .row_i    (row_i),
    .col_i    (col_i),
    .heat_i   (heat_i),
    .cols_i   (cols_q),
    .coef_x_i (coef_x_q),
    .coef_y_i (coef_y_q),
    .value_o  (value_o),
    .stat_o   (dp_stat)
  );

endmodule

@@ tb/sv/tb_heat_diffusion_stencil_step.sv @@
// Self-checking testbench for the heat diffusion stencil block: cell access, sweeps, config.
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_step;
  import hds_pkg::*;

  // Unused command code: no effect, plain zero reply
  localparam logic [CmdW-1:0] CmdSpare = 2'd3;
  // Slowest correct run: clearing pass, then every beat a full 64x64 sweep
  // plus sender gaps; taken a few times over.
  localparam int CycleLimit = 2_000_000;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             status;
  } cell_reply_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start       = 1'b0;
  logic                     busy;
  logic [CmdW-1:0]          cmd_i       = '0;
  logic [IdxW-1:0]          row_i       = '0;
  logic [IdxW-1:0]          col_i       = '0;
  logic signed [DataW-1:0]  heat_i      = '0;
  logic                     done_o;
  logic signed [DataW-1:0]  value_o;
  logic                     status_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CfgDataW-1:0]      cfg_data_i  = '0;

  // Shadow of the block: grid contents and register file
  logic signed [DataW-1:0]  temp_grid [MAX_ROWS][MAX_COLS];
  logic [SizeW-1:0]         rows_cfg   = RowsRst;
  logic [SizeW-1:0]         cols_cfg   = ColsRst;
  logic [CoefW-1:0]         coef_x_cfg = CoefRst;
  logic [CoefW-1:0]         coef_y_cfg = CoefRst;

  cell_reply_t              reply_q [$];
  cell_reply_t              next_reply;
  int                       fail_cnt  = 0;
  int                       cycle_cnt = 0;
  bit                       gaps_on   = 1'b1;

  heat_diffusion_stencil_step u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .heat_i      (heat_i),
    .done_o      (done_o),
    .value_o     (value_o),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Size registers act clamped to 1..vmax
  function automatic int effective_size(input logic [SizeW-1:0] v, input int vmax);
    if (v == '0) return 1;
    if (int'(v) > vmax) return vmax;
    return int'(v);
  endfunction

  // One Jacobi sweep over the interior; every tap reads the pre-sweep grid
  function automatic void diffuse_grid(input int nr, input int nc);
    logic signed [DataW-1:0] prev [MAX_ROWS][MAX_COLS];
    longint t, d_row, d_col, delta, nxt;
    if (nr < 3 || nc < 3) return;
    prev = temp_grid;
    for (int i = 1; i < nr - 1; i++) begin
      for (int j = 1; j < nc - 1; j++) begin
        t     = longint'(prev[i][j]);
        d_row = longint'(prev[i+1][j]) - 2 * t + longint'(prev[i-1][j]);
        d_col = longint'(prev[i][j+1]) - 2 * t + longint'(prev[i][j-1]);
        // round half up: add half an LSB, then floor
        delta = (d_row * longint'(coef_x_cfg) + d_col * longint'(coef_y_cfg)
                 + longint'(RoundHalf)) >>> FracW;
        nxt   = t + delta;
        if (nxt > longint'(SatMax)) temp_grid[i][j] = SatMax;
        else if (nxt < longint'(SatMin)) temp_grid[i][j] = SatMin;
        else temp_grid[i][j] = nxt[DataW-1:0];
      end
    end
  endfunction

  // Apply one accepted command beat to the shadow and queue its reply
  function automatic void predict_reply(input logic [CmdW-1:0] op, input logic [IdxW-1:0] r,
                                        input logic [IdxW-1:0] c,
                                        input logic signed [DataW-1:0] h);
    cell_reply_t rep;
    int nr, nc;
    bit hit;
    nr  = effective_size(rows_cfg, MAX_ROWS);
    nc  = effective_size(cols_cfg, MAX_COLS);
    hit = (int'(r) < nr) && (int'(c) < nc);
    rep = '0;
    case (op)
      CMD_SET: begin
        if (hit) temp_grid[r][c] = h;
        else rep.status = 1'b1;
      end
      CMD_STEP: diffuse_grid(nr, nc);
      CMD_READ: begin
        if (hit) rep.value = temp_grid[r][c];
        else rep.status = 1'b1;
      end
      default: ;
    endcase
    reply_q.push_back(rep);
  endfunction

  function automatic logic signed [DataW-1:0] rand_heat();
    case ($urandom_range(3))
      0: return DataW'($urandom);
      // within +-100.0
      1: return DataW'($urandom_range(0, 32'h00C8_0000)) - DataW'(32'h0064_0000);
      2: begin
        if ($urandom_range(1)) return SatMax - DataW'($urandom_range(0, 65535));
        return SatMin + DataW'($urandom_range(0, 65535));
      end
      default: return $signed(DataW'($urandom)) >>> $urandom_range(4, 20);
    endcase
  endfunction

  // Mostly grids with an interior, sometimes degenerate ones
  function automatic logic [SizeW-1:0] rand_small_size();
    if ($urandom_range(9) < 2) return SizeW'($urandom_range(0, 2));
    return SizeW'($urandom_range(3, 8));
  endfunction

  // Called at a falling edge; returns at a falling edge with start still high,
  // so back-to-back beats never lower and raise start in one step.
  task automatic send_cmd(input logic [CmdW-1:0] op, input logic [IdxW-1:0] r,
                          input logic [IdxW-1:0] c, input logic signed [DataW-1:0] h);
    if (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 50);
    end
    start  <= 1'b1;
    cmd_i  <= op;
    row_i  <= r;
    col_i  <= c;
    heat_i <= h;
    do @(posedge clk_i); while (busy);
    predict_reply(op, r, c, h);
    @(negedge clk_i);
  endtask

  // Hold off until every reply is in and the block reports idle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROWS:   rows_cfg   = data[SizeW-1:0];
      CFG_COLS:   cols_cfg   = data[SizeW-1:0];
      CFG_COEF_X: coef_x_cfg = data[CoefW-1:0];
      CFG_COEF_Y: coef_y_cfg = data[CoefW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CfgDataW-1:0] rows_d, input logic [CfgDataW-1:0] cols_d,
                           input logic [CfgDataW-1:0] cx, input logic [CfgDataW-1:0] cy);
    wait_idle();
    write_cfg(CFG_ROWS, rows_d);
    write_cfg(CFG_COLS, cols_d);
    write_cfg(CFG_COEF_X, cx);
    write_cfg(CFG_COEF_Y, cy);
  endtask

  // Reset sizes and coefficients: corners, extremes, a never-written cell, spare code
  task automatic test_cell_access();
    send_cmd(CMD_SET, 0, 0, SatMax);
    send_cmd(CMD_SET, 63, 63, SatMin);
    send_cmd(CMD_SET, 0, 63, 32'sh5555_AAAA);
    send_cmd(CMD_READ, 0, 0, '0);
    send_cmd(CMD_READ, 63, 63, '1);
    send_cmd(CMD_READ, 0, 63, '0);
    send_cmd(CMD_READ, 42, 21, '0);
    send_cmd(CmdSpare, 63, 63, '1);
    send_cmd(CMD_READ, 63, 63, '0);
  endtask

  // One sweep over the full 64x64 grid with reset coefficients
  task automatic test_full_sweep();
    send_cmd(CMD_SET, 1, 1, 32'sh0064_0000);
    send_cmd(CMD_STEP, 0, 0, '0);
    send_cmd(CMD_READ, 1, 1, '0);
    send_cmd(CMD_READ, 1, 2, '0);
  endtask

  // 3x3 grid, full-scale coefficients: first sweep clips low, second clips high
  task automatic test_saturation();
    configure(16'd3, 16'd3, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_SET, 1, 1, SatMax);
    send_cmd(CMD_SET, 0, 1, SatMin);
    send_cmd(CMD_STEP, 0, 0, '0);
    send_cmd(CMD_READ, 1, 1, '0);
    send_cmd(CMD_STEP, 0, 0, '0);
    send_cmd(CMD_READ, 1, 1, '0);
  endtask

  // rows written as zero (upper data bits set, masked off) acts as one row; 1x2 grid
  task automatic test_small_grid();
    configure(16'hFF80, 16'h0002, CfgDataW'($urandom), CfgDataW'($urandom));
    send_cmd(CMD_SET, 0, 1, rand_heat());
    send_cmd(CMD_SET, 0, 2, rand_heat());
    send_cmd(CMD_READ, 1, 0, '0);
    send_cmd(CMD_STEP, 0, 0, '0);
    send_cmd(CMD_READ, 0, 1, '0);
  endtask

  // Writes past the register list must leave everything unchanged
  task automatic test_ignored_index();
    wait_idle();
    for (int idx = int'(CFG_COEF_Y) + 1; idx < 2 ** CfgIdxW; idx++) begin
      write_cfg(CfgIdxW'(idx), CfgDataW'($urandom));
    end
    send_cmd(CMD_READ, 0, 1, '0);
    send_cmd(CMD_READ, 0, 2, '0);
  endtask

  // Phases of random traffic, each under its own register setting
  task automatic test_random_traffic();
    int nr, nc, roll;
    logic [SizeW-1:0] rs, cs;
    logic [CoefW-1:0] cx, cy;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        rs = SizeW'(MAX_ROWS);
        cs = '1;                    // clamps to the full width
      end else begin
        rs = rand_small_size();
        cs = rand_small_size();
      end
      cx = CoefW'($urandom);
      cy = CoefW'($urandom);
      if (ph == 1) begin
        cx = '0;
        cy = '1;
      end
      if (ph == 2) begin
        cx = '1;
        cy = '0;
      end
      configure({9'($urandom), rs}, {9'($urandom), cs}, cx, cy);
      gaps_on = (ph != 3);          // one phase runs flat out
      nr = effective_size(rows_cfg, MAX_ROWS);
      nc = effective_size(cols_cfg, MAX_COLS);
      for (int k = 0; k < 20; k++) begin
        if (ph == 4 && k == 10) wait_idle();
        roll = $urandom_range(99);
        if (roll < 45) begin
          send_cmd(CMD_SET, IdxW'($urandom_range(0, nr - 1)),
                   IdxW'($urandom_range(0, nc - 1)), rand_heat());
        end else if (roll < 73) begin
          send_cmd(CMD_READ, IdxW'($urandom_range(0, nr - 1)),
                   IdxW'($urandom_range(0, nc - 1)), DataW'($urandom));
        end else if (roll < 83) begin
          send_cmd(CMD_STEP, IdxW'($urandom), IdxW'($urandom), DataW'($urandom));
        end else if (roll < 93) begin
          // any index: mostly out of bounds on the small grids
          send_cmd($urandom_range(1) ? CMD_SET : CMD_READ, IdxW'($urandom),
                   IdxW'($urandom), rand_heat());
        end else begin
          send_cmd(CmdSpare, IdxW'($urandom), IdxW'($urandom), DataW'($urandom));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      for (int j = 0; j < MAX_COLS; j++) temp_grid[i][j] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();                    // clearing pass after reset
    test_cell_access();
    test_full_sweep();
    test_saturation();
    test_small_grid();
    test_ignored_index();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Reply checker: each strobed beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (reply_q.size() == 0) begin
        $error("reply with none pending: value %0d status %0b", value_o, status_o);
        fail_cnt++;
      end else begin
        next_reply = reply_q.pop_front();
        if (value_o !== next_reply.value) begin
          $error("value: expected %0d, got %0d", $signed(next_reply.value), value_o);
          fail_cnt++;
        end
        if (status_o !== next_reply.status) begin
          $error("status: expected %0b, got %0b", next_reply.status, status_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
